[hw/rtl/cft_pkg.sv]
// Shared types, constants and helpers for the CSV field tokenizer.
package cft_pkg;

  localparam int HOLD_DEPTH_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_MARK = 1'd1;

  localparam logic [7:0] SEP_RESET   = 8'd44;  // ','
  localparam logic [7:0] QUOTE_RESET = 8'd34;  // '"'

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  // Input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_PEND
  } state_t;

  // What an input transaction does
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_HOLD,
    CLS_DROP,
    CLS_CHAR,
    CLS_FEND,
    CLS_LEND
  } cls_t;

  // Source of the next result
  typedef enum logic [1:0] {
    SRC_ITEM,
    SRC_HELD,
    SRC_PEND
  } out_src_t;

  typedef struct packed {
    logic     take_item;
    logic     out_load;
    out_src_t out_src;
    logic     rd_en;
    logic     idx_inc;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic held_empty;
    logic replay_last;
    logic out_free;
  } status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

[hw/rtl/cft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cft_pkg::HOLD_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/cft_ctrl.sv]
// Controller state machine: sequences input transactions and held-space replay.
module cft_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cft_pkg::status_t sts,
  output cft_pkg::cmd_t    cmd
);

  cft_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cft_pkg::ST_IDLE: begin
        if (in_valid && sts.out_free && sts.cls == cft_pkg::CLS_CHAR && !sts.held_empty) begin
          state_nxt = cft_pkg::ST_READ;
        end
      end
      cft_pkg::ST_READ: begin
        state_nxt = cft_pkg::ST_EMIT;
      end
      cft_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.replay_last ? cft_pkg::ST_PEND : cft_pkg::ST_READ;
        end
      end
      cft_pkg::ST_PEND: begin
        if (sts.out_free) begin
          state_nxt = cft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cft_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.out_src   = cft_pkg::SRC_ITEM;
    case (state_r)
      cft_pkg::ST_IDLE: begin
        in_ready      = sts.out_free;
        cmd.take_item = in_valid && sts.out_free;
        cmd.out_load  = in_valid && sts.out_free &&
                        (sts.cls == cft_pkg::CLS_FEND || sts.cls == cft_pkg::CLS_LEND ||
                         (sts.cls == cft_pkg::CLS_CHAR && sts.held_empty));
      end
      cft_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      cft_pkg::ST_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.out_src  = cft_pkg::SRC_HELD;
        cmd.idx_inc  = sts.out_free;
      end
      cft_pkg::ST_PEND: begin
        cmd.out_load = sts.out_free;
        cmd.out_src  = cft_pkg::SRC_PEND;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/cft_dp.sv]
// Datapath: config registers, quote/field state, whitespace hold store, result register.
module cft_dp #(
  parameter int HOLD_DEPTH = cft_pkg::HOLD_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_op,
  input  logic [7:0]                    in_char_in,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_value,
  output logic                          out_overflow,
  output logic                          out_last,
  input  cft_pkg::cmd_t                 cmd,
  output cft_pkg::status_t              sts
);

  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  // Control state
  logic [7:0]    sep_r, sep_nxt;
  logic [7:0]    quote_r, quote_nxt;
  logic          in_quote_r, in_quote_nxt;
  logic          quote_seen_r, quote_seen_nxt;
  logic          field_started_r, field_started_nxt;
  logic [CW-1:0] held_count_r, held_count_nxt;
  logic          dropped_r, dropped_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload
  logic [7:0]    pend_r, pend_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [7:0]    value_r, value_nxt;
  logic          ovf_r, ovf_nxt;
  logic          last_r, last_nxt;

  logic [7:0]    held_rdata;
  logic          is_q, is_s;
  cft_pkg::cls_t push_cls, cls;
  logic          item_iq, item_qs;

  assign cfg_ready = 1'b1;

  assign is_q = (in_char_in == quote_r);
  assign is_s = (in_char_in == sep_r);

  // Byte that reaches the field-content path
  always_comb begin
    if (!cft_pkg::is_space(in_char_in)) begin
      push_cls = cft_pkg::CLS_CHAR;
    end else if (!field_started_r) begin
      push_cls = cft_pkg::CLS_NONE;  // leading trim
    end else if (held_count_r < CW'(HOLD_DEPTH)) begin
      push_cls = cft_pkg::CLS_HOLD;
    end else begin
      push_cls = cft_pkg::CLS_DROP;
    end
  end

  // Classify the transaction at the input
  always_comb begin
    cls     = cft_pkg::CLS_NONE;
    item_iq = in_quote_r;
    item_qs = 1'b0;
    if (in_op == cft_pkg::OP_EOL) begin
      cls     = cft_pkg::CLS_LEND;
      item_iq = 1'b0;
    end else if (in_quote_r && quote_seen_r) begin
      if (is_q) begin
        cls = push_cls;  // doubled quote: literal
      end else begin
        item_iq = 1'b0;  // section closed, byte handled outside quotes
        cls     = is_s ? cft_pkg::CLS_FEND : push_cls;
      end
    end else if (in_quote_r) begin
      if (is_q) begin
        item_qs = 1'b1;
      end else begin
        cls = push_cls;
      end
    end else begin
      if (is_q) begin
        item_iq = 1'b1;
      end else if (is_s) begin
        cls = cft_pkg::CLS_FEND;
      end else begin
        cls = push_cls;
      end
    end
  end

  assign sts.cls         = cls;
  assign sts.held_empty  = (held_count_r == '0);
  assign sts.replay_last = ((CW'(idx_r) + CW'(1)) == held_count_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    sep_nxt           = sep_r;
    quote_nxt         = quote_r;
    in_quote_nxt      = in_quote_r;
    quote_seen_nxt    = quote_seen_r;
    field_started_nxt = field_started_r;
    held_count_nxt    = held_count_r;
    dropped_nxt       = dropped_r;
    pend_nxt          = pend_r;
    idx_nxt           = idx_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    kind_nxt          = kind_r;
    value_nxt         = value_r;
    ovf_nxt           = ovf_r;
    last_nxt          = last_r;

    if (cfg_valid) begin
      case (cfg_index)
        cft_pkg::REG_SEPARATOR:  sep_nxt   = cfg_data;
        cft_pkg::REG_QUOTE_MARK: quote_nxt = cfg_data;
        default: begin
          sep_nxt = sep_r;
        end
      endcase
    end

    if (cmd.take_item) begin
      in_quote_nxt   = item_iq;
      quote_seen_nxt = item_qs;
      case (cls)
        cft_pkg::CLS_HOLD: held_count_nxt = held_count_r + CW'(1);
        cft_pkg::CLS_DROP: dropped_nxt = 1'b1;
        cft_pkg::CLS_CHAR: begin
          field_started_nxt = 1'b1;
          pend_nxt          = in_char_in;
          idx_nxt           = '0;
        end
        cft_pkg::CLS_FEND, cft_pkg::CLS_LEND: begin
          field_started_nxt = 1'b0;
          held_count_nxt    = '0;
          dropped_nxt       = 1'b0;
        end
        default: begin
          held_count_nxt = held_count_r;
        end
      endcase
    end

    if (cmd.idx_inc) begin
      idx_nxt = idx_r + AW'(1);
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      ovf_nxt       = dropped_r;
      case (cmd.out_src)
        cft_pkg::SRC_HELD: begin
          kind_nxt  = cft_pkg::KIND_CHAR;
          value_nxt = held_rdata;
          last_nxt  = 1'b0;
        end
        cft_pkg::SRC_PEND: begin
          kind_nxt       = cft_pkg::KIND_CHAR;
          value_nxt      = pend_r;
          last_nxt       = 1'b1;
          held_count_nxt = '0;
        end
        default: begin
          last_nxt = 1'b1;
          case (cls)
            cft_pkg::CLS_CHAR: begin
              kind_nxt  = cft_pkg::KIND_CHAR;
              value_nxt = in_char_in;
            end
            cft_pkg::CLS_LEND: begin
              kind_nxt  = cft_pkg::KIND_LINE_END;
              value_nxt = '0;
            end
            default: begin
              kind_nxt  = cft_pkg::KIND_FIELD_END;
              value_nxt = '0;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r           <= cft_pkg::SEP_RESET;
      quote_r         <= cft_pkg::QUOTE_RESET;
      in_quote_r      <= 1'b0;
      quote_seen_r    <= 1'b0;
      field_started_r <= 1'b0;
      held_count_r    <= '0;
      dropped_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      sep_r           <= sep_nxt;
      quote_r         <= quote_nxt;
      in_quote_r      <= in_quote_nxt;
      quote_seen_r    <= quote_seen_nxt;
      field_started_r <= field_started_nxt;
      held_count_r    <= held_count_nxt;
      dropped_r       <= dropped_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    idx_r   <= idx_nxt;
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    ovf_r   <= ovf_nxt;
    last_r  <= last_nxt;
  end

  // Held whitespace; written at the fill count, replayed from index 0
  cft_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH),
    .AW    (AW)
  ) u_hold (
    .clk   (clk),
    .we    (cmd.take_item && cls == cft_pkg::CLS_HOLD),
    .waddr (held_count_r[AW-1:0]),
    .wdata (in_char_in),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (held_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_value    = value_r;
  assign out_overflow = ovf_r;
  assign out_last     = last_r;

endmodule

[hw/rtl/csv_field_tokenizer.sv]
// Order: a result is registered in the cycle after its input transaction is accepted;
//   the first replayed byte of held whitespace is registered after the READ and EMIT states.
// Throughput: one input transaction per cycle, set by the single result register;
//   the input waits while it is stalled or a replay runs. A character that follows
//   held whitespace starts one: a RAM read and an emit per byte, then the character.
// Reset: synchronous, active low; clears quote/field state, fill count and result valid,
//   and sets separator to ',' and quote mark to '"'. No clearing pass is needed.
module csv_field_tokenizer #(
  parameter int HOLD_DEPTH = cft_pkg::HOLD_DEPTH_DEF  // 1..256
) (
  input  logic                          clk,
  input  logic                          rst_n,

  // Input channel: one line byte or end of line per transaction
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [7:0]                    in_char_in,

  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_value,
  output logic                          out_overflow,
  output logic                          out_last,

  // Configuration write channel, always ready
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  // Commands from the controller, status back from the datapath
  cft_pkg::cmd_t    cmd;
  cft_pkg::status_t sts;

  // The controller takes a transaction only when the result register is free
  // (empty or being drained this cycle). A character that follows held
  // whitespace sends it to a replay loop: read one held byte, emit it, repeat,
  // then emit the character itself with last set.
  cft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath classifies the byte at the input (quote handling, separator,
  // whitespace trim) and holds all tokenizer state, the hold RAM and the
  // result register.
  cft_dp #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_op),
    .in_char_in   (in_char_in),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_overflow (out_overflow),
    .out_last     (out_last),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

[hw/rtl/cft_checker.sv]
// Port-level checks for the tokenizer, bound to the top level.
module cft_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_kind,
  input logic [7:0]                    out_value,
  input logic                          out_last
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
    else $error("result changed while stalled");

  // Field and line ends carry zero and close their transaction
  a_end_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != cft_pkg::KIND_CHAR |-> out_value == 8'd0 && out_last)
    else $error("bad field end result");

  // No new transaction enters while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_ready)
    else $error("input taken with result register full");

  // Replay in progress blocks the input
  a_replay_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !(in_valid && in_ready))
    else $error("input taken during replay");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_value (out_value),
  .out_last  (out_last)
);

[tb/tb_top.sv]
// Self-checking testbench for the CSV field tokenizer: random lines, config sweeps, scoreboard.
`timescale 1ns / 100ps

module tb_top;

  localparam int HOLD_DEPTH = cft_pkg::HOLD_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 40;  // full hold replay plus margin

  // One expected result transaction
  typedef struct {
    logic [1:0] kind;
    logic [7:0] value;
    logic       ovf;
    logic       last;
  } tok_result_t;

  // Line tokenizer model plus the queue of results it has predicted
  class csv_token_model;
    logic [7:0]  sep_byte;
    logic [7:0]  quote_byte;
    bit          in_quote;
    bit          quote_seen;
    bit          field_started;
    bit          dropped;
    logic [7:0]  held[$];
    tok_result_t tokens_due[$];
    int          errors;

    function new();
      sep_byte      = cft_pkg::SEP_RESET;
      quote_byte    = cft_pkg::QUOTE_RESET;
      in_quote      = 1'b0;
      quote_seen    = 1'b0;
      field_started = 1'b0;
      dropped       = 1'b0;
      errors        = 0;
    endfunction

    function void set_reg(logic [cft_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == cft_pkg::REG_SEPARATOR) sep_byte = data;
      else if (idx == cft_pkg::REG_QUOTE_MARK) quote_byte = data;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == cft_pkg::CH_SPACE) || (c == cft_pkg::CH_TAB) ||
             (c == cft_pkg::CH_CR) || (c == cft_pkg::CH_LF);
    endfunction

    function void add_token(logic [1:0] kind, logic [7:0] value);
      tok_result_t r;
      r.kind  = kind;
      r.value = value;
      r.ovf   = dropped;
      r.last  = 1'b0;
      tokens_due.insert(tokens_due.size(), r);
    endfunction

    function void field_char(logic [7:0] c);
      if (is_blank(c)) begin
        if (!field_started) return;        // leading trim, no flag
        if (held.size() < HOLD_DEPTH) held.insert(held.size(), c);
        else dropped = 1'b1;
        return;
      end
      foreach (held[i]) add_token(cft_pkg::KIND_CHAR, held[i]);
      held.delete();
      add_token(cft_pkg::KIND_CHAR, c);
      field_started = 1'b1;
    endfunction

    function void close_field(logic [1:0] kind);
      add_token(kind, 8'h00);
      field_started = 1'b0;
      held.delete();
      dropped = 1'b0;
    endfunction

    function void plain_byte(logic [7:0] c);
      if (c == quote_byte) in_quote = 1'b1;  // quote test wins over separator
      else if (c == sep_byte) close_field(cft_pkg::KIND_FIELD_END);
      else field_char(c);
    endfunction

    // Accepted input transaction: predict every result it causes
    function void take_byte(logic op, logic [7:0] c);
      int n0;
      n0 = tokens_due.size();
      if (op == cft_pkg::OP_EOL) begin
        in_quote   = 1'b0;
        quote_seen = 1'b0;
        close_field(cft_pkg::KIND_LINE_END);
      end else if (in_quote) begin
        if (quote_seen) begin
          quote_seen = 1'b0;
          if (c == quote_byte) field_char(c);
          else begin
            in_quote = 1'b0;
            plain_byte(c);
          end
        end else if (c == quote_byte) quote_seen = 1'b1;
        else field_char(c);
      end else plain_byte(c);
      if (tokens_due.size() > n0) tokens_due[tokens_due.size()-1].last = 1'b1;
    endfunction

    // Accepted result transaction: compare with the oldest prediction
    function void check_token(logic [1:0] kind, logic [7:0] value, logic ovf, logic last);
      tok_result_t e;
      if (tokens_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d value %02h ovf %0b last %0b",
                   kind, value, ovf, last);
        return;
      end
      e = tokens_due.pop_front();
      if (kind !== e.kind || value !== e.value || ovf !== e.ovf || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp kind %0d value %02h ovf %0b last %0b, got %0d %02h %0b %0b",
                   e.kind, e.value, e.ovf, e.last, kind, value, ovf, last);
      end
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins (every input known from time zero)
  // ---------------------------------------------------------------------------
  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_op        = cft_pkg::OP_BYTE;
  logic [7:0]                    in_char_in   = 8'h00;
  logic                          out_ready    = 1'b0;
  logic                          cfg_valid    = 1'b0;
  logic [cft_pkg::CFG_IDX_W-1:0] cfg_index    = cft_pkg::REG_SEPARATOR;
  logic [7:0]                    cfg_data     = 8'h00;
  logic                          in_ready;
  logic                          out_valid;
  logic [1:0]                    out_kind;
  logic [7:0]                    out_value;
  logic                          out_overflow;
  logic                          out_last;
  logic                          cfg_ready;

  csv_token_model sb;
  int             sent     = 0;   // accepted input transactions
  bit             no_gaps  = 1'b0; // burst stretch: neither side idles

  always #5 clk = ~clk;

  csv_field_tokenizer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_char_in   (in_char_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_overflow (out_overflow),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Input side. Everything is driven with NBAs right after a rising edge and
  // handshakes are sampled right after the edge, i.e. the pre-edge values.
  // Valid is lowered only when a gap follows, so a back-to-back transaction
  // never sees valid dropped and raised in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [7:0] ch);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_char_in <= ch;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.take_byte(op, ch);
    sent++;
  endtask

  // Hold off the sender until every predicted result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Quiet point for register writes: drained, then the worst replay time,
  // since trailing whitespace transactions produce nothing to wait on
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between them
  task automatic load_regs(input logic [7:0] sep, input logic [7:0] quote);
    logic [cft_pkg::CFG_IDX_W-1:0] idx;
    logic [7:0]                    data;
    for (int i = 0; i < 2; i++) begin
      idx  = (i == 0) ? cft_pkg::REG_SEPARATOR : cft_pkg::REG_QUOTE_MARK;
      data = (i == 0) ? sep : quote;
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.set_reg(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return cft_pkg::CH_SPACE;
      1:       return cft_pkg::CH_TAB;
      2:       return cft_pkg::CH_CR;
      default: return cft_pkg::CH_LF;
    endcase
  endfunction

  // Field content: mostly printable, sometimes any byte; never the
  // current separator or quote mark
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h21, 8'h7e))
                                      : 8'($urandom_range(0, 255));
    end while (c == sb.sep_byte || c == sb.quote_byte);
    return c;
  endfunction

  task automatic send_blanks(input int n);
    repeat (n) send_item(cft_pkg::OP_BYTE, blank_byte());
  endtask

  // Field body; inner whitespace runs, now and then longer than the hold
  // store, and doubled quote marks when inside a quoted section
  task automatic send_body(input bit quoted);
    int len;
    len = $urandom_range(0, 5);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0)
        send_blanks(($urandom_range(0, 4) == 0) ? $urandom_range(HOLD_DEPTH + 1, HOLD_DEPTH + 4)
                                                : $urandom_range(1, 3));
      if (quoted && $urandom_range(0, 5) == 0) begin
        send_item(cft_pkg::OP_BYTE, sb.quote_byte);
        send_item(cft_pkg::OP_BYTE, sb.quote_byte);
      end else begin
        send_item(cft_pkg::OP_BYTE, text_byte());
      end
    end
  endtask

  // One random line: mostly well-formed fields with random content, some
  // raw noise, unterminated quotes and mid-line pauses
  task automatic send_line();
    int nf;
    int shape;
    no_gaps = ($urandom_range(0, 3) == 0);
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_item(cft_pkg::OP_BYTE, sb.sep_byte);
      send_blanks($urandom_range(0, 2));
      shape = $urandom_range(0, 9);
      if (shape < 5) begin
        send_body(1'b0);
      end else if (shape < 8) begin
        send_item(cft_pkg::OP_BYTE, sb.quote_byte);
        send_body(1'b1);
        send_blanks($urandom_range(0, 2));
        if ($urandom_range(0, 7) != 0) send_item(cft_pkg::OP_BYTE, sb.quote_byte);
      end else begin
        repeat ($urandom_range(1, 4)) send_item(cft_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      end
      send_blanks($urandom_range(0, 2));
      if ($urandom_range(0, 29) == 0) drain();
    end
    send_item(cft_pkg::OP_EOL, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per transaction, zero during burst stretches
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_token(out_kind, out_value, out_overflow, out_last);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    // Leading trim, char 00/FF, separator, quoted field with a doubled quote,
    // blanks trimmed inside quotes, unterminated quote at end of line
    logic [7:0] line_a[$];
    // Closing quote left waiting for lookahead when the line ends
    logic [7:0] line_b[$];
    line_a = '{cft_pkg::CH_SPACE, 8'h61, 8'h00, cft_pkg::CH_TAB, 8'h2c, 8'h22,
               cft_pkg::CH_SPACE, 8'h71, 8'h22, 8'h22, 8'h7a, cft_pkg::CH_CR, 8'h22,
               cft_pkg::CH_LF, 8'h2c, 8'hff, 8'h22, 8'h78};
    line_b = '{8'h22, 8'h6b, cft_pkg::CH_SPACE, 8'h22};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 0: reset values, directed lines then random ones
    foreach (line_a[i]) send_item(cft_pkg::OP_BYTE, line_a[i]);
    send_item(cft_pkg::OP_EOL, 8'hff);
    drain();  // sender held until every result is back
    foreach (line_b[i]) send_item(cft_pkg::OP_BYTE, line_b[i]);
    send_item(cft_pkg::OP_EOL, 8'h00);
    while (sent < 115) send_line();

    // Phase 1: extreme register values
    settle();
    load_regs(8'h00, 8'hff);
    while (sent < 205) send_line();

    // Phase 2: separator equal to quote mark, quoting wins
    settle();
    load_regs(8'h3b, 8'h3b);
    while (sent < 295) send_line();

    // Phase 3: whitespace as quote mark and as separator
    settle();
    load_regs(cft_pkg::CH_TAB, cft_pkg::CH_SPACE);
    while (sent < 385) send_line();

    // Phase 4: arbitrary register values
    settle();
    load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    while (sent < 475) send_line();

    settle();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
